@@ design/gn_pkg.sv @@
`timescale 1ns / 1ps
package gn_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = 8;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_1D   = 2'd1;
    localparam logic [1:0] OP_2D   = 2'd2;
    localparam logic [1:0] OP_3D   = 2'd3;

    localparam logic [IDX_W-1:0] PERM [TABLE_SIZE] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

endpackage

@@ design/gn_front.sv @@
`timescale 1ns / 1ps
// coordinate split, chained hash lookups and corner gradients (stages 1 to 5)
module gn_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [1:0]                  opcode,
    input  logic signed [31:0]          coord_x,
    input  logic signed [31:0]          coord_y,
    input  logic signed [31:0]          coord_z,
    output logic signed [FRAC_BITS:0]   frac [3],
    output logic [1:0]                  op_out,
    output logic signed [FRAC_BITS+2:0] grad [8]
);
    localparam int FW = FRAC_BITS + 1;
    localparam int OW = FRAC_BITS + 2;
    localparam int GW = FRAC_BITS + 3;
    localparam int IW = gn_pkg::IDX_W;
    localparam logic signed [OW-1:0] ONE_O = OW'(64'sd1 <<< FRAC_BITS);

    logic signed [31:0] crd [3];
    assign crd[0] = coord_x;
    assign crd[1] = coord_y;
    assign crd[2] = coord_z;

    // stage 1: split
    logic [IW-1:0]        idx1_reg [3];
    logic [IW-1:0]        idx1_next [3];
    logic signed [FW-1:0] frac1_reg [3];
    logic signed [FW-1:0] frac1_next [3];
    logic [1:0]           op1_reg;

    always_comb
    begin
        logic [32:0]          mag;
        logic [IW-1:0]        ip;
        logic [FRAC_BITS-1:0] fm;
        for (int k = 0; k < 3; k++)
        begin
            mag = crd[k][31] ? -(33'(crd[k])) : 33'(crd[k]);
            ip  = mag[FRAC_BITS+IW-1:FRAC_BITS];
            fm  = mag[FRAC_BITS-1:0];
            idx1_next[k]  = crd[k][31] ? -ip : ip;
            frac1_next[k] = crd[k][31] ? -FW'({1'b0, fm}) : FW'({1'b0, fm});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg  <= idx1_next;
            frac1_reg <= frac1_next;
            op1_reg   <= opcode;
        end
    end

    assign frac = frac1_reg;

    // stage 2: x hashes
    logic [IW-1:0]        hx2_reg [2];
    logic [IW-1:0]        yi2_reg, zi2_reg;
    logic signed [FW-1:0] f2_reg [3];
    logic [1:0]           op2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx2_reg[0] <= gn_pkg::PERM[idx1_reg[0]];
            hx2_reg[1] <= gn_pkg::PERM[idx1_reg[0] + IW'(1)];
            yi2_reg    <= idx1_reg[1];
            zi2_reg    <= idx1_reg[2];
            f2_reg     <= frac1_reg;
            op2_reg    <= op1_reg;
        end
    end

    // stage 3: y hashes, corner index dx + 2*dy
    logic [IW-1:0]        hx3_reg [2];
    logic [IW-1:0]        hy3_reg [4];
    logic [IW-1:0]        zi3_reg;
    logic signed [FW-1:0] f3_reg [3];
    logic [1:0]           op3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                hy3_reg[c] <= gn_pkg::PERM[hx2_reg[c%2] + yi2_reg + IW'(c/2)];
            end
            hx3_reg <= hx2_reg;
            zi3_reg <= zi2_reg;
            f3_reg  <= f2_reg;
            op3_reg <= op2_reg;
        end
    end

    // stage 4: z hashes
    logic [IW-1:0]        hx4_reg [2];
    logic [IW-1:0]        hy4_reg [4];
    logic [IW-1:0]        hz4_reg [8];
    logic signed [FW-1:0] f4_reg [3];
    logic [1:0]           op4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 8; c++)
            begin
                hz4_reg[c] <= gn_pkg::PERM[hy3_reg[c%4] + zi3_reg + IW'(c/4)];
            end
            hx4_reg <= hx3_reg;
            hy4_reg <= hy3_reg;
            f4_reg  <= f3_reg;
            op4_reg <= op3_reg;
        end
    end

    // stage 5: gradient dot products
    logic signed [GW-1:0] g5_reg [8];
    logic signed [GW-1:0] g5_next [8];
    logic [1:0]           op5_reg;

    always_comb
    begin
        logic [3:0]           h;
        logic signed [OW-1:0] ox, oy, oz, p, q;
        for (int c = 0; c < 8; c++)
        begin
            unique case (op4_reg)
                gn_pkg::OP_3D: h = hz4_reg[c][3:0];
                gn_pkg::OP_2D: h = hy4_reg[c%4][3:0];
                default:       h = hx4_reg[c%2][3:0];
            endcase
            ox = OW'(f4_reg[0]) - (((c % 2) == 1) ? ONE_O : '0);
            oy = (op4_reg == gn_pkg::OP_2D || op4_reg == gn_pkg::OP_3D)
                 ? OW'(f4_reg[1]) - ((((c / 2) % 2) == 1) ? ONE_O : '0) : '0;
            oz = (op4_reg == gn_pkg::OP_3D)
                 ? OW'(f4_reg[2]) - (((c / 4) == 1) ? ONE_O : '0) : '0;
            p = (h < 4'd8) ? ox : oy;
            q = (h < 4'd4) ? oy : ((h == 4'd12 || h == 4'd14) ? ox : oz);
            g5_next[c] = (h[0] ? -GW'(p) : GW'(p)) + (h[1] ? -GW'(q) : GW'(q));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g5_reg  <= g5_next;
            op5_reg <= op4_reg;
        end
    end

    assign grad   = g5_reg;
    assign op_out = op5_reg;

endmodule

@@ design/gn_fade.sv @@
`timescale 1ns / 1ps
// fade weight, Horner form: a linear first stage, then one rounded multiply per stage (five stages)
module gn_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [FRAC_BITS:0]   t,
    output logic signed [FRAC_BITS+5:0] s
);
    localparam int FW = FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 6;
    localparam int MW = PW + FW;
    localparam logic signed [PW-1:0] ONE  = PW'(64'sd1 <<< FRAC_BITS);
    localparam logic [MW-1:0]        HALF = MW'(64'd1 << (FRAC_BITS - 1));

    // product rounded to nearest, ties away from zero
    function automatic logic signed [PW-1:0] rnd(input logic signed [MW-1:0] p);
        logic [MW-1:0] m;
        logic [MW-1:0] r;
        m = p[MW-1] ? -p : p;
        r = (m + HALF) >> FRAC_BITS;
        return p[MW-1] ? -PW'(r) : PW'(r);
    endfunction

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, s_reg;
    logic signed [FW-1:0] t0_reg, t1_reg, t2_reg, t3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= (PW'(t) <<< 2) + (PW'(t) <<< 1) - (ONE <<< 4) + ONE;
            t0_reg <= t;
            p1_reg <= rnd(MW'(p0_reg) * MW'(t0_reg)) + (ONE <<< 3) + (ONE <<< 1);
            t1_reg <= t0_reg;
            p2_reg <= rnd(MW'(p1_reg) * MW'(t1_reg));
            t2_reg <= t1_reg;
            p3_reg <= rnd(MW'(p2_reg) * MW'(t2_reg));
            t3_reg <= t2_reg;
            s_reg  <= rnd(MW'(p3_reg) * MW'(t3_reg));
        end
    end

    assign s = s_reg;

endmodule

@@ design/gn_lerp.sv @@
`timescale 1ns / 1ps
// a + round((b - a) * s), or a when pass is set: difference stage, then multiply stage
module gn_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [FRAC_BITS+23:0] a,
    input  logic signed [FRAC_BITS+23:0] b,
    input  logic                         pass,
    input  logic signed [FRAC_BITS+5:0]  s,
    output logic signed [FRAC_BITS+23:0] y
);
    localparam int VW = FRAC_BITS + 24;
    localparam int SW = FRAC_BITS + 6;
    localparam int MW = VW + SW;
    localparam logic [MW-1:0] HALF = MW'(64'd1 << (FRAC_BITS - 1));

    function automatic logic signed [VW-1:0] rnd(input logic signed [MW-1:0] p);
        logic [MW-1:0] m;
        logic [MW-1:0] r;
        m = p[MW-1] ? -p : p;
        r = (m + HALF) >> FRAC_BITS;
        return p[MW-1] ? -VW'(r) : VW'(r);
    endfunction

    logic signed [VW-1:0] a_reg, d_reg, y_reg;
    logic                 pass_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a;
            d_reg    <= b - a;
            pass_reg <= pass;
            y_reg    <= pass_reg ? a_reg : a_reg + rnd(MW'(d_reg) * MW'(s));
        end
    end

    assign y = y_reg;

endmodule

@@ design/gradient_noise_1d_2d_3d_top.sv @@
`timescale 1ns / 1ps
// channel | signals                                  | transfer when
// in      | in_valid in_ready opcode coord_x/y/z     | in_valid && in_ready
// out     | out_valid out_ready noise_value          | out_valid && out_ready
//
// Twelve-stage pipeline: one sample per cycle while the output is not stalled.
// Stages: split, three hash lookups, gradients, fade multiplies in parallel,
// then x, y and z blends (two stages each) and saturation.
// Reset clears only the stage valid bits.
// When the last stage holds a result that is not taken, the whole pipeline halts.
module gradient_noise_1d_2d_3d_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [18:0] noise_value
);
    localparam int NS = 12;
    localparam int FW = FRAC_BITS + 1;
    localparam int GW = FRAC_BITS + 3;
    localparam int SW = FRAC_BITS + 6;
    localparam int VW = FRAC_BITS + 24;
    localparam logic signed [VW-1:0] LIM = VW'(64'sd2 <<< FRAC_BITS);

    logic          en;
    logic [NS-1:0] vld_reg;

    assign en        = !vld_reg[NS-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    logic signed [FW-1:0] frac [3];
    logic [1:0]           op5;
    logic signed [GW-1:0] grad [8];

    gn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk     (clk),
        .en      (en),
        .opcode  (opcode),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .coord_z (coord_z),
        .frac    (frac),
        .op_out  (op5),
        .grad    (grad)
    );

    logic signed [SW-1:0] s6 [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_fade
        gn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
            .clk (clk),
            .en  (en),
            .t   (frac[k]),
            .s   (s6[k])
        );
    end

    // op through stages 6..11, fade weights of y and z delayed to their blends
    logic [1:0]           op_reg [6];
    logic signed [SW-1:0] sy_reg [2];
    logic signed [SW-1:0] sz_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0] <= op5;
            for (int i = 1; i < 6; i++)
            begin
                op_reg[i] <= op_reg[i-1];
            end
            sy_reg[0] <= s6[1];
            sy_reg[1] <= sy_reg[0];
            sz_reg[0] <= s6[2];
            for (int i = 1; i < 4; i++)
            begin
                sz_reg[i] <= sz_reg[i-1];
            end
        end
    end

    logic signed [VW-1:0] lx [4];
    logic signed [VW-1:0] ly [2];
    logic signed [VW-1:0] lz;

    for (genvar k = 0; k < 4; k++)
    begin : g_lx
        gn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
            .clk  (clk),
            .en   (en),
            .a    (VW'(grad[2*k])),
            .b    (VW'(grad[2*k+1])),
            .pass (1'b0),
            .s    (s6[0]),
            .y    (lx[k])
        );
    end

    for (genvar k = 0; k < 2; k++)
    begin : g_ly
        gn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
            .clk  (clk),
            .en   (en),
            .a    (lx[2*k]),
            .b    (lx[2*k+1]),
            .pass (op_reg[1] == gn_pkg::OP_1D),
            .s    (sy_reg[1]),
            .y    (ly[k])
        );
    end

    gn_lerp #(.FRAC_BITS(FRAC_BITS)) u_lz (
        .clk  (clk),
        .en   (en),
        .a    (ly[0]),
        .b    (ly[1]),
        .pass (op_reg[3] != gn_pkg::OP_3D),
        .s    (sz_reg[3]),
        .y    (lz)
    );

    logic signed [18:0] noise_reg;
    logic signed [18:0] noise_next;

    always_comb
    begin
        logic signed [VW-1:0] sat;
        if (lz > LIM)
        begin
            sat = LIM;
        end
        else if (lz < -LIM)
        begin
            sat = -LIM;
        end
        else
        begin
            sat = lz;
        end
        noise_next = (op_reg[5] == gn_pkg::OP_NONE) ? '0 : sat[18:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            noise_reg <= noise_next;
        end
    end

    assign noise_value = noise_reg;

endmodule

@@ verif/tb_gradient_noise_1d_2d_3d_top.sv @@
`timescale 1ns / 1ps
module tb_gradient_noise_1d_2d_3d_top;

    localparam int FRAC = 16;
    localparam longint ONE_Q = 64'sd1 <<< FRAC;
    localparam int N_RANDOM = 1430;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          has_exp;
        logic [18:0] exp_val;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = gn_pkg::OP_NONE;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [18:0] noise_value;

    logic [18:0] expected_samples[$];
    int          mismatches = 0;
    bit          stim_done = 1'b0;
    stim_t       directed[$];

    gradient_noise_1d_2d_3d_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
    );

    always #6 clk = ~clk;

    // round(a*b / 2^FRAC), ties away from zero
    function automatic longint q_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        bit neg;
        p = 128'(signed'(a)) * 128'(signed'(b));
        neg = p[127];
        m = neg ? 128'(-p) : 128'(p);
        m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
        return neg ? -longint'(m[62:0]) : longint'(m[62:0]);
    endfunction

    function automatic longint fade_w(longint t);
        longint p;
        p = 6 * t - 15 * ONE_Q;
        p = q_mul(p, t) + 10 * ONE_Q;
        p = q_mul(p, t);
        p = q_mul(p, t);
        return q_mul(p, t);
    endfunction

    function automatic longint blend(longint a, longint b, longint s);
        return a + q_mul(b - a, s);
    endfunction

    function automatic longint grad_dot(logic [3:0] h, longint x, longint y, longint z);
        longint p, q;
        p = (h < 8) ? x : y;
        q = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return (h[0] ? -p : p) + (h[1] ? -q : q);
    endfunction

    function automatic void split_coord(logic [31:0] raw, output logic [7:0] idx,
                                        output longint frac);
        longint s;
        longint m;
        s = longint'(signed'(raw));
        m = (s < 0) ? -s : s;
        if (s < 0)
        begin
            idx = 8'(-(m >>> FRAC));
            frac = -(m & (ONE_Q - 1));
        end
        else
        begin
            idx = 8'(m >>> FRAC);
            frac = m & (ONE_Q - 1);
        end
    endfunction

    function automatic logic [18:0] noise_sample(logic [1:0] op, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z);
        logic [7:0] xi, yi, zi, h;
        longint fx, fy, fz, gy, gz, res;
        longint v[8];
        int n, dx, dy, dz;
        if (op == gn_pkg::OP_NONE)
            return '0;
        split_coord(x, xi, fx);
        split_coord(y, yi, fy);
        split_coord(z, zi, fz);
        n = 1 << op;
        for (int c = 0; c < n; c++)
        begin
            dx = c & 1;
            dy = (c >> 1) & 1;
            dz = (c >> 2) & 1;
            h = gn_pkg::PERM[8'(xi + dx)];
            gy = 0;
            gz = 0;
            if (op >= gn_pkg::OP_2D)
            begin
                h = gn_pkg::PERM[8'(h + yi + dy)];
                gy = fy - dy * ONE_Q;
            end
            if (op == gn_pkg::OP_3D)
            begin
                h = gn_pkg::PERM[8'(h + zi + dz)];
                gz = fz - dz * ONE_Q;
            end
            v[c] = grad_dot(h[3:0], fx - dx * ONE_Q, gy, gz);
        end
        for (int k = 0; k < n / 2; k++)
            v[k] = blend(v[2 * k], v[2 * k + 1], fade_w(fx));
        n /= 2;
        if (op >= gn_pkg::OP_2D)
        begin
            for (int k = 0; k < n / 2; k++)
                v[k] = blend(v[2 * k], v[2 * k + 1], fade_w(fy));
            n /= 2;
        end
        if (op == gn_pkg::OP_3D)
            v[0] = blend(v[0], v[1], fade_w(fz));
        res = v[0];
        if (res > 2 * ONE_Q)
            res = 2 * ONE_Q;
        if (res < -2 * ONE_Q)
            res = -2 * ONE_Q;
        return res[18:0];
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [31:0] rand_coord();
        unique case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< FRAC;
        endcase
    endfunction

    task automatic add_row(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit has_exp = 0, logic [18:0] ev = '0);
        stim_t s;
        s = '{op, x, y, z, has_exp, ev};
        directed.push_back(s);
    endtask

    task automatic send_sample(stim_t s);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= s.op;
        coord_x <= s.x;
        coord_y <= s.y;
        coord_z <= s.z;
        expected_samples.push_back(s.has_exp ? s.exp_val : noise_sample(s.op, s.x, s.y, s.z));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        stim_t s;
        // lattice points give zero; opcode zero is zero regardless of coords
        add_row(gn_pkg::OP_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1, '0);
        add_row(gn_pkg::OP_1D, 32'h0000_0000, 32'h0, 32'h0, 1, '0);
        add_row(gn_pkg::OP_2D, 32'h0003_0000, 32'hFFFB_0000, 32'h0, 1, '0);
        add_row(gn_pkg::OP_3D, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1, '0);
        add_row(gn_pkg::OP_1D, 32'h7FFF_FFFF, 32'h0, 32'h0);
        add_row(gn_pkg::OP_1D, 32'h8000_0000, 32'h0, 32'h0);
        add_row(gn_pkg::OP_1D, 32'hFFFF_FFFF, 32'h0, 32'h0);
        add_row(gn_pkg::OP_1D, 32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(gn_pkg::OP_2D, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        add_row(gn_pkg::OP_2D, 32'h8000_0000, 32'h8000_0000, 32'h0);
        add_row(gn_pkg::OP_2D, 32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_FFFF);
        add_row(gn_pkg::OP_2D, 32'hFFFF_0001, 32'hFFFF_FFFF, 32'h0);
        add_row(gn_pkg::OP_3D, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_row(gn_pkg::OP_3D, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_row(gn_pkg::OP_3D, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(gn_pkg::OP_3D, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        add_row(gn_pkg::OP_3D, 32'hFFFF_8000, 32'h0012_4000, 32'hFF00_C000);
        add_row(gn_pkg::OP_3D, 32'h00FF_7FFF, 32'h0100_8001, 32'hFFFE_0001);
        add_row(gn_pkg::OP_NONE, 32'h0, 32'h0, 32'h0, 1, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_sample(directed[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            s.op = ($urandom_range(0, 29) == 0) ? gn_pkg::OP_NONE : 2'($urandom_range(1, 3));
            s.x = rand_coord();
            s.y = rand_coord();
            s.z = rand_coord();
            s.has_exp = 0;
            send_sample(s);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stalls; run of no stalls in the middle section
    initial
    begin
        int n;
        n = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (n > 400 && n < 700)
                out_ready <= 1'b1;
            else
                out_ready <= (gap_len() == 0);
            n++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, actual %h", $time,
                         noise_value);
                mismatches++;
            end
            else
            begin
                logic [18:0] ev;
                ev = expected_samples.pop_front();
                if (noise_value !== ev)
                begin
                    $display("%0t: noise_value expected %h, actual %h", $time, ev,
                             noise_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
